FILE: design/abke_pkg.sv
package abke_pkg;

    localparam int TIME_BITS_DEF = 47;
    localparam int SUM_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int KIND_W     = 2;
    localparam int TS_W       = 48;
    localparam int ARR_W      = 47;
    localparam int BYTES_W    = 16;
    localparam int BPS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 15;
    localparam int ELAPSED_W  = 16;
    localparam int EST_INT_W  = 32;
    localparam int VAR_INT_W  = 16;
    localparam int MUL_MIN_W  = 24;

    localparam int BIT_SHIFT   = 3;
    localparam int U_SHIFT     = 8;
    localparam int TEN_SCALE   = 10;
    localparam int BPS_SCALE   = 1000;

    localparam logic [WIN_W-1:0] RATE_WINDOW_RST    = 15'd150;
    localparam logic [WIN_W-1:0] INITIAL_WINDOW_RST = 15'd500;
    localparam logic [15:0]      INITIAL_VAR_RST    = 16'd50;
    localparam logic [15:0]      PROCESS_NOISE_RST  = 16'd5;
    localparam logic [15:0]      FAST_BOOST_RST     = 16'd200;

    typedef enum logic [KIND_W-1:0] {
        KIND_PACKET  = 2'd0,
        KIND_ALR_END = 2'd1,
        KIND_RESET   = 2'd2,
        KIND_SPARE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_WINDOW      = 3'd0,
        REG_INITIAL_WINDOW   = 3'd1,
        REG_INITIAL_VARIANCE = 3'd2,
        REG_PROCESS_NOISE    = 3'd3,
        REG_FAST_BOOST       = 3'd4
    } cfg_reg_t;

endpackage

FILE: design/abke_fb_if.sv
interface abke_fb_if;
    logic                                valid;
    logic                                ready;
    logic [abke_pkg::KIND_W-1:0]         kind;
    logic signed [abke_pkg::TS_W-1:0]    send_ts;
    logic [abke_pkg::ARR_W-1:0]          recv_ts;
    logic [abke_pkg::BYTES_W-1:0]        payload_bytes;
    logic                                batch_last;

    modport source
    (
        output valid, kind, send_ts, recv_ts, payload_bytes, batch_last,
        input  ready
    );
    modport sink
    (
        input  valid, kind, send_ts, recv_ts, payload_bytes, batch_last,
        output ready
    );
endinterface

FILE: design/abke_est_if.sv
interface abke_est_if;
    logic                          valid;
    logic                          ready;
    logic [abke_pkg::BPS_W-1:0]    bitrate_bps;
    logic                          estimate_present;
    logic                          sample_taken;
    logic                          batch_end;

    modport source
    (
        output valid, bitrate_bps, estimate_present, sample_taken, batch_end,
        input  ready
    );
    modport sink
    (
        input  valid, bitrate_bps, estimate_present, sample_taken, batch_end,
        output ready
    );
endinterface

FILE: design/abke_cfg_if.sv
interface abke_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [abke_pkg::CFG_IDX_W-1:0]    index;
    logic [abke_pkg::CFG_DATA_W-1:0]   data;

    modport source
    (
        output valid, index, data,
        input  ready
    );
    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: design/acked_bitrate_kalman_estimator.sv
// A packet that closes no window passes the prep and window states; other requests go straight
// to the output. A long gap adds one serial NW-bit division (NW = 68 at defaults). A closed
// window adds up to four divisions and four multiplies.
// Throughput: one request at a time; the next is taken the cycle after the result is taken.
// Reset: asynchronous, active low; clears estimator state and loads register defaults.
module acked_bitrate_kalman_estimator #(
    parameter int TIME_BITS = abke_pkg::TIME_BITS_DEF,
    parameter int SUM_BITS  = abke_pkg::SUM_BITS_DEF,
    parameter int FRAC_BITS = abke_pkg::FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    abke_fb_if.sink    feedback,
    abke_est_if.source estimate,
    abke_cfg_if.sink   cfg
);

    import abke_pkg::*;

    localparam int EW  = EST_INT_W + FRAC_BITS;
    localparam int VW  = VAR_INT_W + FRAC_BITS;
    localparam int CW  = TIME_BITS + 1;
    localparam int SNW = SUM_BITS + BIT_SHIFT + FRAC_BITS;
    localparam int TW  = EW + 4;
    localparam int UNW = TW + FRAC_BITS;
    localparam int NW0 = (CW > SNW) ? CW : SNW;
    localparam int NW  = (NW0 > UNW) ? NW0 : UNW;
    localparam int DW  = EW;
    localparam int UW  = U_SHIFT + FRAC_BITS;
    localparam int MW  = (UW > MUL_MIN_W) ? UW : MUL_MIN_W;
    localparam int MO  = EW + MW - FRAC_BITS;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_PREP  = 16'h0002,
        S_MOD   = 16'h0004,
        S_WIN   = 16'h0008,
        S_SMP   = 16'h0010,
        S_KD    = 16'h0020,
        S_KU    = 16'h0040,
        S_KSQ   = 16'h0080,
        S_KDEN  = 16'h0100,
        S_KK    = 16'h0200,
        S_KSTEP = 16'h0400,
        S_KS    = 16'h0800,
        S_KVAR  = 16'h1000,
        S_BPS   = 16'h2000,
        S_BPSW  = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    state_t                  state_reg;

    logic [WIN_W-1:0]        rate_win_reg;
    logic [WIN_W-1:0]        init_win_reg;
    logic [15:0]             init_var_reg;
    logic [15:0]             pnoise_reg;
    logic [15:0]             boost_reg;

    logic signed [TS_W-1:0]  sts_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [BYTES_W-1:0]      bytes_reg;
    logic                    last_reg;
    logic [WIN_W-1:0]        wnd_reg;

    logic [TIME_BITS-1:0]    prev_time_reg;
    logic                    prev_valid_reg;
    logic [ELAPSED_W-1:0]    elapsed_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [EW-1:0]           est_reg;
    logic                    est_valid_reg;
    logic [VW-1:0]           var_reg;
    logic signed [TS_W-1:0]  alr_reg;

    logic [CW-1:0]           cur_reg;
    logic [EW-1:0]           sample_reg;
    logic [EW-1:0]           d_reg;
    logic                    up_reg;
    logic [VW-1:0]           pvar_reg;
    logic [VW-1:0]           sv_reg;
    logic [VW:0]             den_reg;
    logic [BPS_W-1:0]        bps_reg;
    logic                    taken_reg;

    logic                    div_start_reg;
    logic [NW-1:0]           div_num_reg;
    logic [DW-1:0]           div_den_reg;
    logic                    div_done;
    logic [NW-1:0]           div_quo;
    logic [DW-1:0]           div_rem;

    logic                    mul_start_reg;
    logic [EW-1:0]           mul_a_reg;
    logic [MW-1:0]           mul_k_reg;
    logic                    mul_done;
    logic [MO-1:0]           mul_res;

    logic [WIN_W-1:0]        wnd_sel;
    logic                    jump;
    logic [TIME_BITS-1:0]    gap;
    logic [CW-1:0]           cur_add;
    logic [VW:0]             boost_sum;
    logic [VW:0]             noise_sum;
    logic [CW-1:0]           cur_sub;
    logic [CW-1:0]           cur_keep;
    logic [ELAPSED_W-1:0]    elapsed_new;
    logic [SUM_BITS:0]       sum_add;
    logic [EW-1:0]           samp;
    logic [EW-1:0]           d_cmb;
    logic [TW-1:0]           ten_d;
    logic [EW+U_SHIFT-1:0]   e_big;
    logic [VW:0]             den_cmb;
    logic [EW-1:0]           est_step;

    abke_div #(
        .NW (NW),
        .DW (DW)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    abke_mul #(
        .AW   (EW),
        .MW   (MW),
        .FRAC (FRAC_BITS)
    )
    u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .k     (mul_k_reg),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_comb
    begin
        wnd_sel = est_valid_reg ? rate_win_reg : init_win_reg;
        if (wnd_sel == '0)
        begin
            wnd_sel = WIN_W'(1);
        end
    end

    assign jump      = prev_valid_reg && (now_reg < prev_time_reg);
    assign gap       = now_reg - prev_time_reg;
    assign cur_add   = CW'(elapsed_reg) + CW'(gap);
    assign boost_sum = (VW+1)'(var_reg) + (VW+1)'({boost_reg, {FRAC_BITS{1'b0}}});
    assign noise_sum = (VW+1)'(var_reg) + (VW+1)'({pnoise_reg, {FRAC_BITS{1'b0}}});
    assign cur_sub   = cur_reg - CW'(wnd_reg);
    assign cur_keep  = (cur_reg >= CW'(wnd_reg)) ? cur_sub : cur_reg;
    assign elapsed_new = (cur_keep > CW'({ELAPSED_W{1'b1}})) ? {ELAPSED_W{1'b1}}
                                                             : cur_keep[ELAPSED_W-1:0];
    assign sum_add   = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(bytes_reg);
    assign samp      = (div_quo[NW-1:EW] != '0) ? {EW{1'b1}} : div_quo[EW-1:0];
    assign d_cmb     = (est_reg > sample_reg) ? est_reg - sample_reg : sample_reg - est_reg;
    assign ten_d     = TW'(d_cmb) * TW'(TEN_SCALE);
    assign e_big     = (EW+U_SHIFT)'(est_reg) << U_SHIFT;
    assign den_cmb   = (VW+1)'(sv_reg) + (VW+1)'(pvar_reg);
    assign est_step  = mul_res[EW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_win_reg <= RATE_WINDOW_RST;
            init_win_reg <= INITIAL_WINDOW_RST;
            init_var_reg <= INITIAL_VAR_RST;
            pnoise_reg   <= PROCESS_NOISE_RST;
            boost_reg    <= FAST_BOOST_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_RATE_WINDOW:      rate_win_reg <= cfg.data[WIN_W-1:0];
                REG_INITIAL_WINDOW:   init_win_reg <= cfg.data[WIN_W-1:0];
                REG_INITIAL_VARIANCE: init_var_reg <= cfg.data;
                REG_PROCESS_NOISE:    pnoise_reg   <= cfg.data;
                REG_FAST_BOOST:       boost_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
            elapsed_reg    <= '0;
            sum_reg        <= '0;
            est_reg        <= '0;
            est_valid_reg  <= 1'b0;
            var_reg        <= VW'({INITIAL_VAR_RST, {FRAC_BITS{1'b0}}});
            alr_reg        <= '1;
            bps_reg        <= '0;
            taken_reg      <= 1'b0;
            div_start_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (feedback.valid)
                    begin
                        sts_reg   <= feedback.send_ts;
                        now_reg   <= TIME_BITS'(feedback.recv_ts);
                        bytes_reg <= feedback.payload_bytes;
                        last_reg  <= feedback.batch_last;
                        wnd_reg   <= wnd_sel;
                        taken_reg <= 1'b0;
                        state_reg <= S_OUT;
                        case (feedback.kind)
                            KIND_PACKET:
                            begin
                                if (!feedback.send_ts[TS_W-1])
                                begin
                                    state_reg <= S_PREP;
                                end
                            end
                            KIND_ALR_END:
                            begin
                                alr_reg <= feedback.send_ts;
                            end
                            KIND_RESET:
                            begin
                                prev_time_reg  <= '0;
                                prev_valid_reg <= 1'b0;
                                elapsed_reg    <= '0;
                                sum_reg        <= '0;
                                est_reg        <= '0;
                                est_valid_reg  <= 1'b0;
                                var_reg        <= VW'({init_var_reg, {FRAC_BITS{1'b0}}});
                                alr_reg        <= '1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    if (!alr_reg[TS_W-1] && (sts_reg > alr_reg))
                    begin
                        var_reg <= boost_sum[VW] ? {VW{1'b1}} : boost_sum[VW-1:0];
                        alr_reg <= '1;
                    end
                    prev_time_reg  <= now_reg;
                    prev_valid_reg <= 1'b1;
                    state_reg      <= S_WIN;
                    if (jump)
                    begin
                        sum_reg <= '0;
                        cur_reg <= '0;
                    end
                    else if (prev_valid_reg)
                    begin
                        cur_reg <= cur_add;
                        if (gap > TIME_BITS'(wnd_reg))
                        begin
                            sum_reg       <= '0;
                            div_num_reg   <= NW'(cur_add);
                            div_den_reg   <= DW'(wnd_reg);
                            div_start_reg <= 1'b1;
                            state_reg     <= S_MOD;
                        end
                    end
                    else
                    begin
                        cur_reg <= CW'(elapsed_reg);
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        cur_reg   <= CW'(div_rem);
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    elapsed_reg <= elapsed_new;
                    if (cur_reg >= CW'(wnd_reg))
                    begin
                        taken_reg     <= 1'b1;
                        sum_reg       <= SUM_BITS'(bytes_reg);
                        div_num_reg   <= NW'({sum_reg, {BIT_SHIFT{1'b0}},
                                              {FRAC_BITS{1'b0}}});
                        div_den_reg   <= DW'(wnd_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_SMP;
                    end
                    else
                    begin
                        sum_reg   <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}}
                                                       : sum_add[SUM_BITS-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_SMP:
                begin
                    if (div_done)
                    begin
                        if (!est_valid_reg)
                        begin
                            est_reg       <= samp;
                            est_valid_reg <= 1'b1;
                            state_reg     <= S_BPS;
                        end
                        else
                        begin
                            sample_reg <= samp;
                            state_reg  <= S_KD;
                        end
                    end
                end
                S_KD:
                begin
                    d_reg    <= d_cmb;
                    up_reg   <= sample_reg >= est_reg;
                    pvar_reg <= noise_sum[VW] ? {VW{1'b1}} : noise_sum[VW-1:0];
                    if (d_cmb == '0)
                    begin
                        sv_reg    <= '0;
                        state_reg <= S_KDEN;
                    end
                    else if ((est_reg == '0) || ((EW+U_SHIFT)'(ten_d) >= e_big))
                    begin
                        sv_reg    <= {VW{1'b1}};
                        state_reg <= S_KDEN;
                    end
                    else
                    begin
                        div_num_reg   <= NW'({ten_d, {FRAC_BITS{1'b0}}});
                        div_den_reg   <= DW'(est_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_KU;
                    end
                end
                S_KU:
                begin
                    if (div_done)
                    begin
                        mul_a_reg     <= EW'(div_quo[UW-1:0]);
                        mul_k_reg     <= MW'(div_quo[UW-1:0]);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_KSQ;
                    end
                end
                S_KSQ:
                begin
                    if (mul_done)
                    begin
                        sv_reg    <= (mul_res[MO-1:VW] != '0) ? {VW{1'b1}}
                                                              : mul_res[VW-1:0];
                        state_reg <= S_KDEN;
                    end
                end
                S_KDEN:
                begin
                    if (den_cmb == '0)
                    begin
                        est_reg   <= sample_reg;
                        var_reg   <= '0;
                        state_reg <= S_BPS;
                    end
                    else
                    begin
                        den_reg       <= den_cmb;
                        div_num_reg   <= NW'({pvar_reg, {FRAC_BITS{1'b0}}});
                        div_den_reg   <= DW'(den_cmb);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_KK;
                    end
                end
                S_KK:
                begin
                    if (div_done)
                    begin
                        mul_a_reg     <= d_reg;
                        mul_k_reg     <= MW'(div_quo);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_KSTEP;
                    end
                end
                S_KSTEP:
                begin
                    if (mul_done)
                    begin
                        est_reg       <= up_reg ? est_reg + est_step : est_reg - est_step;
                        div_num_reg   <= NW'({sv_reg, {FRAC_BITS{1'b0}}});
                        div_den_reg   <= DW'(den_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_KS;
                    end
                end
                S_KS:
                begin
                    if (div_done)
                    begin
                        mul_a_reg     <= EW'(pvar_reg);
                        mul_k_reg     <= MW'(div_quo);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_KVAR;
                    end
                end
                S_KVAR:
                begin
                    if (mul_done)
                    begin
                        var_reg   <= mul_res[VW-1:0];
                        state_reg <= S_BPS;
                    end
                end
                S_BPS:
                begin
                    mul_a_reg     <= est_reg;
                    mul_k_reg     <= MW'(BPS_SCALE);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_BPSW;
                end
                S_BPSW:
                begin
                    if (mul_done)
                    begin
                        bps_reg   <= (mul_res[MO-1:BPS_W] != '0) ? {BPS_W{1'b1}}
                                                                 : mul_res[BPS_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (estimate.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign feedback.ready            = (state_reg == S_IDLE);
    assign cfg.ready                 = 1'b1;
    assign estimate.valid            = (state_reg == S_OUT);
    assign estimate.bitrate_bps      = est_valid_reg ? bps_reg : '0;
    assign estimate.estimate_present = est_valid_reg;
    assign estimate.sample_taken     = taken_reg;
    assign estimate.batch_end        = last_reg;

`ifndef SYNTHESIS
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        feedback.valid && feedback.ready |=> !feedback.ready)
        else $error("request accepted while previous one in progress");

    a_sample_has_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        estimate.valid && estimate.sample_taken |-> estimate.estimate_present)
        else $error("sample taken without an estimate");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MOD) || (state_reg == S_SMP) || (state_reg == S_KU)
                     || (state_reg == S_KK) || (state_reg == S_KS))
        else $error("divider finished outside a wait state");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_KSQ) || (state_reg == S_KSTEP)
                     || (state_reg == S_KVAR) || (state_reg == S_BPSW))
        else $error("multiplier finished outside a wait state");
`endif

endmodule

FILE: design/abke_div.sv
module abke_div #(
    parameter int NW = 68,
    parameter int DW = 48
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {r_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg <= {q_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule

FILE: design/abke_mul.sv
module abke_mul #(
    parameter int AW   = 48,
    parameter int MW   = 24,
    parameter int FRAC = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        a,
    input  logic [MW-1:0]        k,
    output logic                 done,
    output logic [AW+MW-FRAC-1:0] res
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_HI   = 4'b0010,
        M_LO   = 4'b0100,
        M_ACC  = 4'b1000
    } mul_state_t;

    mul_state_t       state_reg;
    logic [AW-1:0]    a_reg;
    logic [MW-1:0]    k_reg;
    logic [2*MW-1:0]  p_reg;
    logic [AW+MW-1:0] acc_reg;
    logic             done_reg;
    logic [MW-1:0]    mul_x;
    logic [2*MW-1:0]  prod;

    assign mul_x = (state_reg == M_HI) ? MW'(a_reg[AW-1:MW]) : a_reg[MW-1:0];
    assign prod  = mul_x * k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= M_HI;
                    end
                end
                M_HI:
                begin
                    state_reg <= M_LO;
                end
                M_LO:
                begin
                    state_reg <= M_ACC;
                end
                M_ACC:
                begin
                    state_reg <= M_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        if (state_reg == M_IDLE && start)
        begin
            a_reg <= a;
            k_reg <= k;
        end
        if (state_reg == M_LO)
        begin
            acc_reg <= (AW+MW)'({p_reg, {MW{1'b0}}});
        end
        if (state_reg == M_ACC)
        begin
            acc_reg <= acc_reg + (AW+MW)'(p_reg);
        end
    end

    assign done = done_reg;
    assign res  = acc_reg[AW+MW-1:FRAC];

endmodule

FILE: bench/tb_acked_bitrate_kalman_estimator.sv
`timescale 1ns / 100ps
module tb_acked_bitrate_kalman_estimator;
    import abke_pkg::*;

    localparam int FB = 16;
    localparam logic [63:0] EST_MAX = (64'd1 << 48) - 1;
    localparam logic [63:0] VAR_MAX = (64'd1 << 32) - 1;
    localparam logic [63:0] SUM_MAX = (64'd1 << 32) - 1;
    localparam logic [63:0] T_MASK  = (64'd1 << 47) - 1;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] send_ts;
        logic [46:0] recv_ts;
        logic [15:0] payload_bytes;
        logic        batch_last;
    } fb_req_t;

    typedef struct packed {
        logic [31:0] bps;
        logic        present;
        logic        taken;
        logic        bend;
    } est_res_t;

    logic clk;
    logic rst_n;

    abke_fb_if  fb_bus();
    abke_est_if est_bus();
    abke_cfg_if cfg_bus();

    acked_bitrate_kalman_estimator u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .feedback (fb_bus.sink),
        .estimate (est_bus.source),
        .cfg      (cfg_bus.sink)
    );

    fb_req_t  pending_reqs[$];
    est_res_t expected_rates[$];
    int       mismatches;
    int       cycles;
    int       fb_gap;
    int       est_gap;
    logic     fb_go;

    logic [63:0] r_win, i_win, i_var, p_noise, boost;
    logic [63:0] prev_t, elapsed, bsum, est_q, var_q;
    logic        prev_ok, est_ok;
    logic signed [63:0] alr_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] div_q(logic [63:0] num, logic [63:0] den,
                                          logic [63:0] lim);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (q > (lim >> FB))
            return lim;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (q > lim) ? lim : q;
    endfunction

    function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] k);
        return (a >> FB) * k + (((a & 64'hFFFF) * k) >> FB);
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] m);
        logic [63:0] s;
        s = a + b;
        return (s > m) ? m : s;
    endfunction

    task automatic clear_estimator();
        prev_t = 0;
        prev_ok = 1'b0;
        elapsed = 0;
        bsum = 0;
        est_q = 0;
        est_ok = 1'b0;
        var_q = (i_var << FB) & VAR_MAX;
        alr_t = -1;
    endtask

    task automatic fuse_sample(logic [63:0] s);
        logic [63:0] e, d, sv, p, den, k, ks, u, st;
        e = est_q;
        d = (e > s) ? e - s : s - e;
        if (d == 0)
            sv = 0;
        else if (e == 0 || 10 * d >= 256 * e)
            sv = VAR_MAX;
        else
        begin
            u = div_q(10 * d, e, 64'hFFFF_FFFF_FFFF_FFFF);
            sv = (u * u) >> FB;
            if (sv > VAR_MAX)
                sv = VAR_MAX;
        end
        p = add_sat(var_q, p_noise << FB, VAR_MAX);
        den = sv + p;
        if (den == 0)
        begin
            est_q = s;
            var_q = 0;
        end
        else
        begin
            k = div_q(p, den, 64'hFFFF_FFFF_FFFF_FFFF);
            ks = div_q(sv, den, 64'hFFFF_FFFF_FFFF_FFFF);
            st = mul_q(d, k);
            est_q = (s >= e) ? e + st : e - st;
            if (est_q > EST_MAX)
                est_q = EST_MAX;
            var_q = mul_q(p, ks);
        end
    endtask

    task automatic predict_rate(fb_req_t q);
        logic signed [63:0] sts;
        logic [63:0] now, wnd, cur, smp, bps;
        logic taken;
        est_res_t res;
        sts = {{16{q.send_ts[47]}}, q.send_ts};
        now = {17'd0, q.recv_ts} & T_MASK;
        taken = 1'b0;
        smp = 0;
        if (q.kind == KIND_ALR_END)
            alr_t = sts;
        else if (q.kind == KIND_RESET)
            clear_estimator();
        else if (q.kind == KIND_PACKET && !q.send_ts[47])
        begin
            wnd = est_ok ? r_win : i_win;
            cur = elapsed;
            if (wnd == 0)
                wnd = 1;
            if (alr_t >= 0 && sts > alr_t)
            begin
                var_q = add_sat(var_q, boost << FB, VAR_MAX);
                alr_t = -1;
            end
            if (prev_ok && now < prev_t)
            begin
                prev_ok = 1'b0;
                bsum = 0;
                cur = 0;
            end
            if (prev_ok)
            begin
                cur = cur + (now - prev_t);
                if (now - prev_t > wnd)
                begin
                    bsum = 0;
                    cur = cur % wnd;
                end
            end
            prev_t = now;
            prev_ok = 1'b1;
            if (cur >= wnd)
            begin
                smp = div_q(bsum * 8, wnd, EST_MAX);
                cur = cur - wnd;
                bsum = 0;
                taken = 1'b1;
            end
            elapsed = (cur > 64'hFFFF) ? 64'hFFFF : cur;
            bsum = add_sat(bsum, {48'd0, q.payload_bytes}, SUM_MAX);
            if (taken)
            begin
                if (!est_ok)
                begin
                    est_q = smp;
                    est_ok = 1'b1;
                end
                else
                    fuse_sample(smp);
            end
        end
        if (est_ok)
        begin
            bps = (est_q >> FB) * 1000 + (((est_q & 64'hFFFF) * 1000) >> FB);
            res.bps = (bps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : bps[31:0];
        end
        else
            res.bps = 32'd0;
        res.present = est_ok;
        res.taken = taken;
        res.bend = q.batch_last;
        expected_rates.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_bus.valid <= 1'b0;
            fb_gap <= 0;
        end
        else
        begin
            if (fb_bus.valid && fb_bus.ready)
                predict_rate({fb_bus.kind, fb_bus.send_ts, fb_bus.recv_ts,
                              fb_bus.payload_bytes, fb_bus.batch_last});
            if (!fb_bus.valid || fb_bus.ready)
            begin
                if (fb_gap > 0)
                begin
                    fb_gap <= fb_gap - 1;
                    fb_bus.valid <= 1'b0;
                end
                else if (fb_go && pending_reqs.size() > 0)
                begin
                    fb_req_t q;
                    q = pending_reqs.pop_front();
                    fb_bus.valid <= 1'b1;
                    fb_bus.kind <= q.kind;
                    fb_bus.send_ts <= q.send_ts;
                    fb_bus.recv_ts <= q.recv_ts;
                    fb_bus.payload_bytes <= q.payload_bytes;
                    fb_bus.batch_last <= q.batch_last;
                    fb_gap <= pick_gap();
                end
                else
                    fb_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_bus.ready <= 1'b0;
            est_gap <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (est_bus.valid && est_bus.ready)
            begin
                est_res_t a;
                est_res_t x;
                a = {est_bus.bitrate_bps, est_bus.estimate_present,
                     est_bus.sample_taken, est_bus.batch_end};
                if (expected_rates.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected estimate %h", a);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    x = expected_rates.pop_front();
                    if (a !== x)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch exp bps=%0d p=%b t=%b b=%b",
                                      " got bps=%0d p=%b t=%b b=%b"},
                                     x.bps, x.present, x.taken, x.bend,
                                     a.bps, a.present, a.taken, a.bend);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (est_gap > 0)
            begin
                est_gap <= est_gap - 1;
                est_bus.ready <= 1'b0;
            end
            else
            begin
                est_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    est_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_RATE_WINDOW:      r_win = {48'd0, val & 16'h7FFF};
            REG_INITIAL_WINDOW:   i_win = {48'd0, val & 16'h7FFF};
            REG_INITIAL_VARIANCE: i_var = {48'd0, val};
            REG_PROCESS_NOISE:    p_noise = {48'd0, val};
            default:              boost = {48'd0, val};
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || fb_bus.valid || expected_rates.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic add_req(logic [1:0] k, logic [47:0] s, logic [46:0] a,
                           logic [15:0] b, logic l);
        fb_req_t q;
        q.kind = k;
        q.send_ts = s;
        q.recv_ts = a;
        q.payload_bytes = b;
        q.batch_last = l;
        pending_reqs.push_back(q);
    endtask

    task automatic run_phase(int n, int wmax);
        logic [46:0] t;
        logic [47:0] s;
        int r;
        t = 47'($urandom_range(0, 1000));
        s = {1'b0, t};
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                t = t + 47'($urandom_range(0, wmax));
                s = s + 48'($urandom_range(0, 20));
                add_req(KIND_PACKET, s, t, 16'($urandom), 1'($urandom));
            end
            else if (r < 85)
                add_req(KIND_ALR_END, s + 48'($urandom_range(0, 30)) - 48'd5,
                        47'({$urandom, $urandom}), 16'($urandom), 1'($urandom));
            else if (r < 87)
                add_req(KIND_RESET, 48'({$urandom, $urandom}), 47'({$urandom, $urandom}),
                        16'($urandom), 1'($urandom));
            else if (r < 90)
                add_req(KIND_PACKET, {1'b1, 15'($urandom), 32'($urandom)}, t,
                        16'($urandom), 1'($urandom));
            else if (r < 93)
            begin
                t = t - 47'($urandom_range(1, 100));
                add_req(KIND_PACKET, s, t, 16'($urandom), 1'($urandom));
            end
            else if (r < 96)
            begin
                t = t + 47'($urandom_range(wmax, 5 * wmax + 1000));
                add_req(KIND_PACKET, s, t, 16'($urandom), 1'($urandom));
            end
            else if (r < 98)
                add_req(KIND_SPARE, 48'({$urandom, $urandom}), 47'({$urandom, $urandom}),
                        16'($urandom), 1'($urandom));
            else
                add_req(KIND_PACKET, {1'b0, 15'($urandom), 32'($urandom)},
                        {15'($urandom), 32'($urandom)}, 16'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        cycles = 0;
        fb_go = 1'b0;
        fb_bus.valid = 1'b0;
        fb_bus.kind = '0;
        fb_bus.send_ts = '0;
        fb_bus.recv_ts = '0;
        fb_bus.payload_bytes = '0;
        fb_bus.batch_last = 1'b0;
        est_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        r_win = 150;
        i_win = 500;
        i_var = 50;
        p_noise = 5;
        boost = 200;
        clear_estimator();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_req(KIND_PACKET, 48'd0, 47'd0, 16'hFFFF, 1'b1);
        add_req(KIND_PACKET, 48'd10, 47'd300, 16'hFFFF, 1'b0);
        add_req(KIND_PACKET, 48'd20, 47'd500, 16'd0, 1'b1);
        add_req(KIND_ALR_END, 48'd25, 47'd0, 16'd0, 1'b0);
        add_req(KIND_PACKET, 48'd30, 47'd650, 16'd1000, 1'b0);
        add_req(KIND_PACKET, 48'd40, 47'd800, 16'd10, 1'b1);
        add_req(KIND_PACKET, 48'hFFFF_FFFF_FFFF, 47'd900, 16'd5, 1'b0);
        add_req(KIND_PACKET, 48'd50, 47'd100, 16'd7, 1'b1);
        add_req(KIND_PACKET, 48'd60, 47'd5000, 16'd7, 1'b0);
        add_req(KIND_PACKET, 48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        add_req(KIND_ALR_END, 48'hFFFF_FFFF_FFFF, 47'd0, 16'd0, 1'b0);
        add_req(KIND_SPARE, 48'd1, 47'd1, 16'd1, 1'b1);
        add_req(KIND_RESET, 48'd0, 47'd0, 16'd0, 1'b0);
        add_req(KIND_PACKET, 48'd1, 47'd1, 16'd1, 1'b0);
        fb_go = 1'b1;
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_RATE_WINDOW, 16'd1);
                    write_reg(REG_INITIAL_WINDOW, 16'd1);
                    write_reg(REG_INITIAL_VARIANCE, 16'd0);
                    write_reg(REG_PROCESS_NOISE, 16'd0);
                    write_reg(REG_FAST_BOOST, 16'd0);
                end
                1:
                begin
                    write_reg(REG_RATE_WINDOW, 16'd30000);
                    write_reg(REG_INITIAL_WINDOW, 16'd30000);
                    write_reg(REG_INITIAL_VARIANCE, 16'hFFFF);
                    write_reg(REG_PROCESS_NOISE, 16'hFFFF);
                    write_reg(REG_FAST_BOOST, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_RATE_WINDOW, 16'd0);
                    write_reg(REG_INITIAL_WINDOW, 16'h7FFF);
                end
                default:
                begin
                    write_reg(REG_RATE_WINDOW, 16'($urandom_range(1, 300)));
                    write_reg(REG_INITIAL_WINDOW, 16'($urandom_range(1, 600)));
                    write_reg(REG_INITIAL_VARIANCE, 16'($urandom));
                    write_reg(REG_PROCESS_NOISE, 16'($urandom_range(0, 50)));
                    write_reg(REG_FAST_BOOST, 16'($urandom));
                end
            endcase
            add_req(KIND_RESET, 48'd0, 47'd0, 16'd0, 1'b0);
            run_phase(220, (ph == 1) ? 9000 : ((ph == 2) ? 3 : 60));
            wait_idle();
        end

        if (mismatches == 0 && expected_rates.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
design/abke_pkg.sv
design/abke_fb_if.sv
design/abke_est_if.sv
design/abke_cfg_if.sv
design/abke_div.sv
design/abke_mul.sv
design/acked_bitrate_kalman_estimator.sv
bench/tb_acked_bitrate_kalman_estimator.sv
